// ===== rtl/sdd_pkg.sv =====
// ----------------------------------------------------------------------------
// sdd_pkg
// Shared types and constants for the signed digit decomposition block.
// ----------------------------------------------------------------------------
package sdd_pkg;

    localparam int SDD_COEFF_WIDTH = 24;
    localparam int SDD_MAX_DIGITS  = 24;

    // Field widths of the words on the ports
    localparam int SDD_VALUE_W = 24;
    localparam int SDD_POS_W   = 5;
    localparam int SDD_BITS_W  = 4;
    localparam int SDD_CNT_W   = 5;
    localparam int SDD_CFG_W   = 24;
    localparam int SDD_IDX_W   = 2;

    // Widest digit: a 4-bit digit_bits register allows up to 15 bits per digit
    localparam int SDD_DIGIT_W = 15;

    // Configuration register indexes
    localparam logic [SDD_IDX_W-1:0] REG_DIGIT_BITS  = 2'd0;
    localparam logic [SDD_IDX_W-1:0] REG_DIGIT_COUNT = 2'd1;
    localparam logic [SDD_IDX_W-1:0] REG_MODULUS     = 2'd2;

    // Reset values of the configuration registers
    localparam logic [SDD_BITS_W-1:0]  RST_DIGIT_BITS  = 4'd2;
    localparam logic [SDD_CNT_W-1:0]   RST_DIGIT_COUNT = 5'd12;
    localparam logic [SDD_VALUE_W-1:0] RST_MODULUS     = 24'd3329;

    typedef struct packed {
        logic [SDD_VALUE_W-1:0] coefficient;
        logic                   last_coefficient;
    } t_coeff_word;

    typedef struct packed {
        logic [SDD_VALUE_W-1:0] digit_value;
        logic [SDD_POS_W-1:0]   digit_position;
        logic                   last_digit;
        logic                   end_of_poly;
    } t_digit_word;

endpackage

// ===== rtl/signed_digit_decompose_mod_q.sv =====
// ----------------------------------------------------------------------------
// signed_digit_decompose_mod_q
// Signed base-2^digit_bits decomposition of coefficients modulo q.
// ----------------------------------------------------------------------------
// Each accepted coefficient word produces min(digit_count, MAX_DIGITS) digit
// words, least significant first, one per cycle while the output is not
// stalled; the final digit carries last_digit, and end_of_poly as well when
// the coefficient was marked last_coefficient. A coefficient above q/2 is
// negated to q - c on entry, and each nonzero digit of it leaves as q - d.
// The single digit extractor emits one digit word per cycle while the output
// is not stalled, so a coefficient occupies it for all of its digits (12 at
// reset); a digit_count of zero consumes the coefficient with no
// output. The next coefficient is taken in the same cycle as the previous
// one's final digit, so the output runs without gaps. Configuration
// (digit_bits, digit_count, modulus at indexes 0, 1, 2) must only be written
// while the block is idle.
// ----------------------------------------------------------------------------
module signed_digit_decompose_mod_q
    import sdd_pkg::*;
#(
    parameter int COEFF_WIDTH = SDD_COEFF_WIDTH,
    parameter int MAX_DIGITS  = SDD_MAX_DIGITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration write port
    input  logic                   i_cfg_we,
    input  logic [SDD_IDX_W-1:0]   i_cfg_index,
    input  logic [SDD_CFG_W-1:0]   i_cfg_data,
    // coefficient words in
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  t_coeff_word            i_in_word,
    // digit words out
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output t_digit_word            o_out_word
);

    localparam int CNT_W = SDD_POS_W + 1;
    localparam logic [SDD_VALUE_W-1:0] COEFF_MASK = (COEFF_WIDTH >= SDD_VALUE_W)
        ? {SDD_VALUE_W{1'b1}}
        : SDD_VALUE_W'((64'd1 << COEFF_WIDTH) - 64'd1);

    // configuration registers
    logic [SDD_BITS_W-1:0]  r_digit_bits;
    logic [SDD_CNT_W-1:0]   r_digit_count;
    logic [SDD_VALUE_W-1:0] r_modulus;

    // working registers of the coefficient in flight
    logic                   r_busy,       n_busy;
    logic [COEFF_WIDTH-1:0] r_value,      n_value;
    logic                   r_neg,        n_neg;
    logic                   r_last_coeff, n_last_coeff;
    logic [SDD_POS_W-1:0]   r_pos,        n_pos;
    logic [SDD_POS_W-1:0]   r_last_pos,   n_last_pos;

    // output register
    logic                   r_out_valid,  n_out_valid;
    t_digit_word            r_out,        n_out;

    logic [CNT_W-1:0]       count;
    logic [SDD_VALUE_W-1:0] coeff;
    logic                   coeff_neg;
    logic [COEFF_WIDTH-1:0] coeff_value;
    logic                   out_free;
    logic                   step;
    logic                   at_last;
    logic                   in_ready;
    logic                   accept;
    logic [SDD_VALUE_W-1:0] digit_value;
    logic [COEFF_WIDTH-1:0] value_next;

    // configuration: hold, overwrite on a write to a known index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit_bits  <= RST_DIGIT_BITS;
            r_digit_count <= RST_DIGIT_COUNT;
            r_modulus     <= RST_MODULUS;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_DIGIT_BITS:  r_digit_bits  <= i_cfg_data[SDD_BITS_W-1:0];
                REG_DIGIT_COUNT: r_digit_count <= i_cfg_data[SDD_CNT_W-1:0];
                REG_MODULUS:     r_modulus     <= i_cfg_data[SDD_VALUE_W-1:0];
                default: ;
            endcase
        end
    end

    // saturate the digit count to the build limit
    assign count = (CNT_W'(r_digit_count) > CNT_W'(MAX_DIGITS))
        ? CNT_W'(MAX_DIGITS) : CNT_W'(r_digit_count);

    // entry: sign test against q/2 and negation modulo 2^COEFF_WIDTH
    assign coeff       = i_in_word.coefficient & COEFF_MASK;
    assign coeff_neg   = coeff > (r_modulus >> 1);
    assign coeff_value = coeff_neg ? (COEFF_WIDTH'(r_modulus) - COEFF_WIDTH'(coeff))
                                   : COEFF_WIDTH'(coeff);

    // emit a digit whenever the output register is empty or being drained
    assign out_free = !r_out_valid || !i_out_stall;
    assign step     = r_busy && out_free;
    assign at_last  = (r_pos == r_last_pos);
    // take the next coefficient as the current one emits its last digit
    assign in_ready = !r_busy || (step && at_last);
    assign accept   = i_in_valid && in_ready;

    assign o_in_stall  = !in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    sdd_digit_unit #(
        .COEFF_WIDTH (COEFF_WIDTH)
    ) u_digit (
        .i_value       (r_value),
        .i_neg         (r_neg),
        .i_digit_bits  (r_digit_bits),
        .i_modulus     (r_modulus),
        .o_digit_value (digit_value),
        .o_value_next  (value_next)
    );

    always_comb begin
        n_busy       = r_busy;
        n_value      = r_value;
        n_neg        = r_neg;
        n_last_coeff = r_last_coeff;
        n_pos        = r_pos;
        n_last_pos   = r_last_pos;
        n_out_valid  = r_out_valid;
        n_out        = r_out;

        // drop the output word once taken
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        // advance one digit into the output register
        if (step) begin
            n_out.digit_value    = digit_value;
            n_out.digit_position = r_pos;
            n_out.last_digit     = at_last;
            n_out.end_of_poly    = at_last && r_last_coeff;
            n_out_valid          = 1'b1;
            n_value              = value_next;
            n_pos                = r_pos + 1'b1;
            if (at_last) begin
                n_busy = 1'b0;
            end
        end

        // load a new coefficient; a zero digit count leaves nothing to emit
        if (accept) begin
            n_busy       = (count != '0);
            n_value      = coeff_value;
            n_neg        = coeff_neg;
            n_last_coeff = i_in_word.last_coefficient;
            n_pos        = '0;
            n_last_pos   = SDD_POS_W'(count - CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
        r_value      <= n_value;
        r_neg        <= n_neg;
        r_last_coeff <= n_last_coeff;
        r_pos        <= n_pos;
        r_last_pos   <= n_last_pos;
        r_out        <= n_out;
    end

endmodule

// ===== rtl/sdd_digit_unit.sv =====
// ----------------------------------------------------------------------------
// sdd_digit_unit
// Extracts the low digit of the working value, maps it to its signed code
// modulo q and gives the working value shifted down by one digit.
// ----------------------------------------------------------------------------
module sdd_digit_unit
    import sdd_pkg::*;
#(
    parameter int COEFF_WIDTH = SDD_COEFF_WIDTH
) (
    input  logic [COEFF_WIDTH-1:0] i_value,
    input  logic                   i_neg,
    input  logic [SDD_BITS_W-1:0]  i_digit_bits,
    input  logic [SDD_VALUE_W-1:0] i_modulus,
    output logic [SDD_VALUE_W-1:0] o_digit_value,
    output logic [COEFF_WIDTH-1:0] o_value_next
);

    logic [SDD_DIGIT_W-1:0] mask;
    logic [SDD_DIGIT_W-1:0] digit;

    // Mask of digit_bits ones; empty when digit_bits is zero
    assign mask  = ~({SDD_DIGIT_W{1'b1}} << i_digit_bits);
    assign digit = SDD_DIGIT_W'(i_value) & mask;

    // Negative nonzero digits are coded as q minus the magnitude
    always_comb begin
        if (i_neg && (digit != '0)) begin
            o_digit_value = i_modulus - SDD_VALUE_W'(digit);
        end else begin
            o_digit_value = SDD_VALUE_W'(digit);
        end
    end

    // Once the shifts pass the value width the remainder is zero,
    // which also covers digits at bit offsets of 32 or more
    assign o_value_next = i_value >> i_digit_bits;

endmodule

// ===== tb/tb_signed_digit_decompose_mod_q.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_signed_digit_decompose_mod_q
// Self-checking bench for the signed digit decomposition block: drives
// coefficient words through a valid/stall port, predicts every digit word
// from a mirror of the configuration registers, and compares the digit
// stream field by field under several settings and idling patterns.
// ----------------------------------------------------------------------------
module tb_signed_digit_decompose_mod_q;
    import sdd_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    // quiet cycles after the last digit before the block is taken as idle
    localparam int SETTLE_CYCLES  = SDD_MAX_DIGITS + 8;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } t_idle_mode;

    // ------------------------------------------------------------------------
    // Digit predictor and scoreboard: mirror the registers, expand each
    // accepted coefficient into its digits, compare the outgoing stream.
    // ------------------------------------------------------------------------
    class digit_scoreboard;
        logic [SDD_BITS_W-1:0]  digit_bits;
        logic [SDD_CNT_W-1:0]   digit_count;
        logic [SDD_VALUE_W-1:0] modulus;
        t_digit_word            pending_digits[$];
        int unsigned            digits_checked;
        int unsigned            mismatches;

        function new();
            digit_bits     = RST_DIGIT_BITS;
            digit_count    = RST_DIGIT_COUNT;
            modulus        = RST_MODULUS;
            digits_checked = 0;
            mismatches     = 0;
        endfunction

        function void write_register(logic [SDD_IDX_W-1:0] idx,
                                     logic [SDD_CFG_W-1:0] data);
            case (idx)
                REG_DIGIT_BITS:  digit_bits  = data[SDD_BITS_W-1:0];
                REG_DIGIT_COUNT: digit_count = data[SDD_CNT_W-1:0];
                REG_MODULUS:     modulus     = data[SDD_VALUE_W-1:0];
                default: ;
            endcase
        endfunction

        // Expand one accepted coefficient word into its expected digit words.
        function void note_coeff(t_coeff_word w);
            int unsigned            n;
            int unsigned            i;
            int unsigned            shift;
            bit                     neg;
            logic [SDD_VALUE_W-1:0] mag;
            logic [SDD_VALUE_W-1:0] mask;
            logic [SDD_VALUE_W-1:0] d;
            t_digit_word            r;
            n    = (digit_count > SDD_MAX_DIGITS) ? SDD_MAX_DIGITS : digit_count;
            neg  = w.coefficient > (modulus >> 1);
            // negation wraps at the coefficient width when c > q
            mag  = neg ? modulus - w.coefficient : w.coefficient;
            mask = (24'd1 << digit_bits) - 24'd1;
            for (i = 0; i < n; i++) begin
                shift = i * digit_bits;
                d = (shift >= 32) ? '0 : ((mag >> shift) & mask);
                // a nonzero digit of a negated value leaves as q - d, mod 2^24
                r.digit_value    = (neg && d != '0) ? modulus - d : d;
                r.digit_position = SDD_POS_W'(i);
                r.last_digit     = (i + 1 == n);
                r.end_of_poly    = r.last_digit & w.last_coefficient;
                pending_digits.push_back(r);
            end
        endfunction

        function void check_digit(t_digit_word got);
            t_digit_word want;
            digits_checked++;
            if (pending_digits.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] unexpected digit: value=%0h pos=%0d last=%0b eop=%0b",
                             $time, got.digit_value, got.digit_position,
                             got.last_digit, got.end_of_poly);
                return;
            end
            want = pending_digits.pop_front();
            if (got.digit_value !== want.digit_value ||
                got.digit_position !== want.digit_position ||
                got.last_digit !== want.last_digit ||
                got.end_of_poly !== want.end_of_poly) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $write("[%0t] digit mismatch: want value=%0h pos=%0d last=%0b eop=%0b",
                           $time, want.digit_value, want.digit_position,
                           want.last_digit, want.end_of_poly);
                    $display(" got value=%0h pos=%0d last=%0b eop=%0b",
                             got.digit_value, got.digit_position,
                             got.last_digit, got.end_of_poly);
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and the block
    // ------------------------------------------------------------------------
    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [SDD_IDX_W-1:0] i_cfg_index;
    logic [SDD_CFG_W-1:0] i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_stall;
    t_coeff_word          i_in_word;
    logic                 o_out_valid;
    logic                 i_out_stall;
    t_digit_word          o_out_word;

    signed_digit_decompose_mod_q dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    digit_scoreboard sb = new();

    int unsigned send_idle_pct;    // chance of an idle cycle before each word
    int unsigned recv_stall_pct;   // chance of stalling the digit port per cycle
    int unsigned coeffs_sent;
    int unsigned settings_used;
    int unsigned poly_left;        // coefficients left in the current polynomial
    int unsigned quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Digit port: check each accepted word, then pick the next stall.
    // Periodically leave a stretch with no stalls.
    // ------------------------------------------------------------------------
    initial begin : digit_sink
        int unsigned cyc;
        cyc = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall)
                sb.check_digit(o_out_word);
            cyc++;
            i_out_stall <= (cyc % 48 >= 12) && ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Watchdog: give up once nothing has moved on either port for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("[%0t] watchdog: no word moved for %0d cycles",
                         $time, WATCHDOG_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driving tasks
    // ------------------------------------------------------------------------
    function automatic t_coeff_word coeff_word(logic [SDD_VALUE_W-1:0] c, logic last);
        t_coeff_word w;
        w.coefficient      = c;
        w.last_coefficient = last;
        return w;
    endfunction

    // Offer one coefficient word and hold it until the block takes it.
    // Valid stays high on return so back-to-back words have no gap.
    task automatic send_coeff(t_coeff_word w);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_coeff(w);
        coeffs_sent++;
    endtask

    // Drop valid, wait for every predicted digit, then let the block go quiet
    // (a zero digit count can leave a word in flight with nothing to show).
    task automatic settle_block();
        i_in_valid <= 1'b0;
        while (sb.pending_digits.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(logic [SDD_IDX_W-1:0] idx, logic [SDD_CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.write_register(idx, data);
    endtask

    task automatic apply_config(int unsigned bits, int unsigned count, int unsigned q);
        settle_block();
        write_register(REG_DIGIT_BITS, SDD_CFG_W'(bits));
        write_register(REG_DIGIT_COUNT, SDD_CFG_W'(count));
        write_register(REG_MODULUS, SDD_CFG_W'(q));
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic set_idle_mode(t_idle_mode mode);
        case (mode)
            IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SEND: begin send_idle_pct = 71; recv_stall_pct = 0;  end
            IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 71; end
            default:   begin send_idle_pct = 34; recv_stall_pct = 34; end
        endcase
    endtask

    // Mostly well-formed coefficients below q, some around q/2, some raw noise.
    function automatic logic [SDD_VALUE_W-1:0] pick_coeff(logic [SDD_VALUE_W-1:0] q);
        int unsigned r;
        r = $urandom_range(19);
        if (r < 14)
            return (q > 0) ? SDD_VALUE_W'($urandom_range(0, q - 1)) : SDD_VALUE_W'($urandom);
        if (r < 17)
            return (q >> 1) + SDD_VALUE_W'($urandom_range(0, 2)) - 24'd1;
        return SDD_VALUE_W'($urandom);
    endfunction

    // Random coefficients grouped into polynomials of random length.
    task automatic run_items(int unsigned n, bit hold_off);
        int unsigned k;
        logic        last;
        for (k = 0; k < n; k++) begin
            if (poly_left == 0)
                poly_left = $urandom_range(1, 16);
            poly_left--;
            last = (poly_left == 0);
            // every so often run a burst with no sender gaps
            if (send_idle_pct != 0 && k % 10 < 3) begin
                int unsigned saved;
                saved = send_idle_pct;
                send_idle_pct = 0;
                send_coeff(coeff_word(pick_coeff(sb.modulus), last));
                send_idle_pct = saved;
            end else begin
                send_coeff(coeff_word(pick_coeff(sb.modulus), last));
            end
            // pause the sender until the digit stream has fully drained
            if (hold_off && k == n / 2) begin
                i_in_valid <= 1'b0;
                while (sb.pending_digits.size() != 0)
                    @(posedge i_clk);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : main_seq
        int unsigned ph;
        int unsigned bits;
        int unsigned count;
        int unsigned q;
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_index    <= REG_DIGIT_BITS;
        i_cfg_data     <= '0;
        i_in_valid     <= 1'b0;
        i_in_word      <= '0;
        i_out_stall    <= 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        coeffs_sent    = 0;
        settings_used  = 1;
        poly_left      = 0;
        quiet_cycles   = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: zero, q/2 boundary on both sides, q - 1, c = q, all ones
        send_coeff(coeff_word(24'd0, 1'b0));
        send_coeff(coeff_word(24'd1, 1'b0));
        send_coeff(coeff_word(24'd1664, 1'b0));
        send_coeff(coeff_word(24'd1665, 1'b0));
        send_coeff(coeff_word(24'd3328, 1'b1));
        send_coeff(coeff_word(24'd3329, 1'b0));
        send_coeff(coeff_word(24'hFFFFFF, 1'b1));

        // Empty digit mask, digit count saturated to the maximum, widest q
        apply_config(0, 31, 24'hFFFFFF);
        send_coeff(coeff_word(24'h7FFFFF, 1'b0));
        send_coeff(coeff_word(24'h800000, 1'b0));
        send_coeff(coeff_word(24'hFFFFFF, 1'b1));

        // Widest digits: offsets of 32 bits and beyond give zero digits
        set_idle_mode(IDLE_BOTH);
        apply_config(15, 24, 2);
        send_coeff(coeff_word(24'd0, 1'b0));
        send_coeff(coeff_word(24'd1, 1'b0));
        send_coeff(coeff_word(24'd2, 1'b1));
        send_coeff(coeff_word(24'hABCDEF, 1'b1));

        // Zero digit count: words are taken with no digits out; q of zero
        apply_config(8, 0, 0);
        send_coeff(coeff_word(24'd5, 1'b0));
        send_coeff(coeff_word(24'h123456, 1'b1));

        // Digit magnitude above q: q - d wraps in the digit field
        apply_config(8, 3, 5);
        send_coeff(coeff_word(24'hFFFFFF, 1'b0));
        send_coeff(coeff_word(24'd3, 1'b0));
        send_coeff(coeff_word(24'd2, 1'b1));

        // Smallest digits and count, q below two
        apply_config(1, 1, 1);
        send_coeff(coeff_word(24'd0, 1'b0));
        send_coeff(coeff_word(24'd1, 1'b1));
        send_coeff(coeff_word(24'hFFFFFF, 1'b1));

        // Random phases: first two at the extremes of the useful range
        for (ph = 0; ph < 8; ph++) begin
            if (ph == 0) begin
                bits = 8; count = 24; q = 24'hFFFFFF;
            end else if (ph == 1) begin
                bits = 1; count = 1; q = 2;
            end else begin
                bits  = ($urandom_range(9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
                count = ($urandom_range(9) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 24);
                case ($urandom_range(5))
                    0:       q = 3329;
                    1:       q = 7681;
                    2:       q = 12289;
                    3:       q = 8380417;
                    4:       q = $urandom_range(2, 24'hFFFFFF);
                    default: q = $urandom_range(0, 24'hFFFFFF);
                endcase
            end
            apply_config(bits, count, q);
            set_idle_mode(t_idle_mode'(ph % 4));
            run_items(26, ph == 2);
        end

        settle_block();
        $display("Covered %0d coefficient words across %0d register settings and four idling patterns;",
                 coeffs_sent, settings_used);
        $display("%0d digit words checked, %0d mismatches, %0d digits never delivered.",
                 sb.digits_checked, sb.mismatches, sb.pending_digits.size());
        if (sb.mismatches == 0 && sb.pending_digits.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/sdd_pkg.sv
rtl/sdd_digit_unit.sv
rtl/signed_digit_decompose_mod_q.sv
tb/tb_signed_digit_decompose_mod_q.sv
